// ===== sv/bil_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bil_pkg: shared types for the bounded indexed list
// Operation codes, request and response payloads, the per-cell control group
// and the controller states.
// ----------------------------------------------------------------------------
package bil_pkg;

   // Operation codes carried in the request kind field
   typedef enum logic [2:0] {
      OP_INSERT  = 3'd0,
      OP_REMOVE  = 3'd1,
      OP_REPLACE = 3'd2,
      OP_SELECT  = 3'd3,
      OP_SEARCH  = 3'd4
   } op_kind_type;

   // Request payload
   typedef struct packed {
      logic [2:0]         kind;
      logic [4:0]         position;
      logic signed [31:0] operand_value;
   } bil_req_type;

   // Response payload
   typedef struct packed {
      logic               ok;
      logic signed [31:0] read_value;
      logic [4:0]         found_position;
      logic [4:0]         count;
      logic               is_empty;
      logic               is_full;
   } bil_rsp_type;

   // Broadcast control from the controller to every cell
   typedef struct packed {
      logic capture;     // sample compare and select flags
      logic do_insert;   // accepted insert, shift up from position
      logic do_remove;   // accepted remove, shift down onto position
      logic do_replace;  // accepted overwrite at position
   } bil_cell_ctl_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_REPORT
   } bil_state_type;

endpackage

// ===== sv/bil_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bil_cell: one list slot
// Holds one entry, takes its left or right neighbor on insert and remove,
// and registers its own search match and select flags.
// ----------------------------------------------------------------------------
module bil_cell import bil_pkg::*; #(
   parameter int INDEX      = 0,
   parameter int AW         = 5,
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  bil_cell_ctl_type      ctl,
   input  logic [AW-1:0]         position,
   input  logic [AW-1:0]         count,
   input  logic [AW-1:0]         target,
   input  logic [VALUE_BITS-1:0] operand,
   input  logic [VALUE_BITS-1:0] left_value,
   input  logic [VALUE_BITS-1:0] right_value,
   output logic [VALUE_BITS-1:0] value,
   output logic                  hit,
   output logic                  pick
);

   localparam logic [AW-1:0] IDX = AW'(INDEX);

   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic                  hit_ff, hit_in;
   logic                  pick_ff, pick_in;

   // Next entry value: shift, overwrite or hold
   always_comb begin
      value_in = value_ff;
      if (ctl.do_insert) begin
         if (IDX == position) begin
            value_in = operand;
         end else if (IDX > position && IDX <= count) begin
            value_in = left_value;
         end
      end else if (ctl.do_remove) begin
         if (IDX >= position && (IDX + AW'(1)) < count) begin
            value_in = right_value;
         end
      end else if (ctl.do_replace) begin
         if (IDX == position) begin
            value_in = operand;
         end
      end
   end

   // Match and select flags, sampled against the pre-operation entry
   always_comb begin
      hit_in  = hit_ff;
      pick_in = pick_ff;
      if (ctl.capture) begin
         hit_in  = (IDX < count) && (value_ff == operand);
         pick_in = (IDX == target);
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      hit_ff   <= hit_in;
      pick_ff  <= pick_in;
   end

   assign value = value_ff;
   assign hit   = hit_ff;
   assign pick  = pick_ff;

endmodule

// ===== sv/bil_gather.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bil_gather: result collection across the cell row
// Finds the first matching cell and reads out the picked cell's entry.
// ----------------------------------------------------------------------------
module bil_gather import bil_pkg::*; #(
   parameter int DEPTH      = 16,
   parameter int AW         = 5,
   parameter int VALUE_BITS = 32
) (
   input  logic [DEPTH-1:0]      hit,
   input  logic [DEPTH-1:0]      pick,
   input  logic [VALUE_BITS-1:0] values [DEPTH],
   output logic                  any_hit,
   output logic [AW-1:0]         first_hit,
   output logic [VALUE_BITS-1:0] read_data
);

   logic [DEPTH-1:0] first_onehot;

   // Isolate the lowest set match bit
   assign first_onehot = hit & (~hit + DEPTH'(1));
   assign any_hit      = |hit;

   // One-hot to index
   always_comb begin
      first_hit = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (first_onehot[i]) begin
            first_hit = first_hit | AW'(i);
         end
      end
   end

   // AND-OR read of the picked cell, zero when none is picked
   always_comb begin
      read_data = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (pick[i]) begin
            read_data = read_data | values[i];
         end
      end
   end

endmodule

// ===== sv/bounded_indexed_list.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_indexed_list: ordered list of signed words addressed by position
// Top level: controller, row of entry cells and result collection.
// ----------------------------------------------------------------------------
// Usage:
//   A request (insert, remove, replace, select or search) transfers at a
//   rising edge with start high and busy low. busy stays high after that
//   edge while the cells shift or compare and the result is collected.
//   The response is shown on rsp_data for exactly one cycle, marked by
//   rsp_valid, once busy has dropped; it must be taken
//   then, as the receiver cannot stall the block.
//   The block takes no new request while busy. The cycle after the transfer
//   the whole row shifts in place and every cell compares in parallel;
//   the next cycle encodes the first match and reads the picked cell.
//   busy drops as the response register loads, so the next request may
//   transfer in the same cycle the response is shown.
//   Reset empties the list (count 0) and clears busy and rsp_valid; entry
//   contents are not cleared, as only entries below the count are read.
// ----------------------------------------------------------------------------
module bounded_indexed_list import bil_pkg::*; #(
   parameter int DEPTH      = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  bil_req_type req_data,
   output logic        rsp_valid,
   output bil_rsp_type rsp_data
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = (CW > 5) ? CW : 5;

   bil_state_type    state_ff, state_in;
   bil_req_type      cmd_ff, cmd_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             ok_ff, ok_in;
   bil_rsp_type      rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             accept;
   logic             capture;
   bil_cell_ctl_type cell_ctl;
   logic [AW-1:0]    pos_ext, count_ext, target;
   logic [VALUE_BITS-1:0] operand;
   logic             ins_ok, idx_ok;

   logic [VALUE_BITS-1:0] cell_value [DEPTH];
   logic [VALUE_BITS-1:0] left_w     [DEPTH];
   logic [VALUE_BITS-1:0] right_w    [DEPTH];
   logic [DEPTH-1:0]      hit_vec, pick_vec;
   logic                  any_hit;
   logic [AW-1:0]         first_hit;
   logic [VALUE_BITS-1:0] read_data;
   logic [63:0]           read_wide;
   logic [AW-1:0]         count_after;

   assign accept = start && !busy;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_EXEC;
         ST_EXEC:   state_in = ST_REPORT;
         ST_REPORT: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      busy    = (state_ff != ST_IDLE);
      capture = (state_ff == ST_EXEC);
   end

   // Command capture
   assign cmd_in = accept ? req_data : cmd_ff;

   // Operand and range checks
   assign operand   = VALUE_BITS'(64'(signed'(cmd_ff.operand_value)));
   assign pos_ext   = AW'(cmd_ff.position);
   assign count_ext = AW'(count_ff);
   assign ins_ok    = (pos_ext <= count_ext) && (count_ff != CW'(DEPTH));
   assign idx_ok    = (pos_ext < count_ext);
   assign target    = idx_ok ? pos_ext : (count_ext - AW'(1));

   // Operation decode for the cell row
   always_comb begin
      cell_ctl         = '0;
      cell_ctl.capture = capture;
      ok_in            = ok_ff;
      count_in         = count_ff;
      if (capture) begin
         ok_in = 1'b0;
         case (op_kind_type'(cmd_ff.kind))
            OP_INSERT: begin
               cell_ctl.do_insert = ins_ok;
               ok_in              = ins_ok;
               if (ins_ok) count_in = count_ff + CW'(1);
            end
            OP_REMOVE: begin
               cell_ctl.do_remove = idx_ok;
               ok_in              = idx_ok;
               if (idx_ok) count_in = count_ff - CW'(1);
            end
            OP_REPLACE: begin
               cell_ctl.do_replace = idx_ok;
               ok_in               = idx_ok;
            end
            OP_SELECT: begin
               ok_in = idx_ok;
            end
            default: begin
               ok_in = 1'b0;
            end
         endcase
      end
   end

   // Cell row
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_left_edge
         assign left_w[i] = cell_value[i];
      end else begin : g_left
         assign left_w[i] = cell_value[i-1];
      end
      if (i == DEPTH - 1) begin : g_right_edge
         assign right_w[i] = cell_value[i];
      end else begin : g_right
         assign right_w[i] = cell_value[i+1];
      end

      bil_cell #(
         .INDEX      (i),
         .AW         (AW),
         .VALUE_BITS (VALUE_BITS)
      ) u_cell (
         .clock       (clock),
         .ctl         (cell_ctl),
         .position    (pos_ext),
         .count       (count_ext),
         .target      (target),
         .operand     (operand),
         .left_value  (left_w[i]),
         .right_value (right_w[i]),
         .value       (cell_value[i]),
         .hit         (hit_vec[i]),
         .pick        (pick_vec[i])
      );
   end

   bil_gather #(
      .DEPTH      (DEPTH),
      .AW         (AW),
      .VALUE_BITS (VALUE_BITS)
   ) u_gather (
      .hit       (hit_vec),
      .pick      (pick_vec),
      .values    (cell_value),
      .any_hit   (any_hit),
      .first_hit (first_hit),
      .read_data (read_data)
   );

   // Response assembly
   assign read_wide   = 64'(signed'(read_data));
   assign count_after = AW'(count_ff);

   always_comb begin
      rsp_in                = '0;
      rsp_in.count          = count_after[4:0];
      rsp_in.is_empty       = (count_ff == '0);
      rsp_in.is_full        = (count_ff == CW'(DEPTH));
      rsp_in.ok             = ok_ff;
      case (op_kind_type'(cmd_ff.kind))
         OP_SELECT: begin
            rsp_in.read_value = read_wide[31:0];
         end
         OP_SEARCH: begin
            rsp_in.ok             = any_hit;
            rsp_in.found_position = any_hit ? first_hit[4:0] : count_after[4:0];
         end
         default: begin
            rsp_in.read_value = '0;
         end
      endcase
   end

   assign rsp_valid_in = (state_ff == ST_REPORT);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      ok_ff  <= ok_in;
      if (rsp_valid_in) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
